FILE: rtl/core/rau_pkg.sv
// rau_pkg: shared constants and types for the rational arithmetic unit
// no dependencies
package rau_pkg;
    localparam int DEF_WIDTH = 32;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
        OP_NEG = 3'd4, OP_CMP = 3'd5, OP_SIMP = 3'd6, OP_NONE = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_ZDEN = 2'd1, ST_DIVZ = 2'd2, ST_OVF = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic [31:0] b_num;
        logic [31:0] b_den;
    } t_req;

    typedef struct packed {
        logic [31:0] res_num;
        logic [30:0] res_den;
        logic        less;
        logic        equal;
        logic [1:0]  status;
    } t_rsp;
endpackage

FILE: rtl/core/rau_if.sv
// rau_if: valid/ready channel carrying a payload of type t_payload
// depends on nothing; payload types come from rau_pkg
interface rau_if #(parameter type t_payload = logic) (input logic i_clk);
    logic     valid;
    logic     ready;
    t_payload data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/rau_mul.sv
// rau_mul: shift-add multiplier, one bit of the multiplier per cycle
// depends on rau_pkg
module rau_mul import rau_pkg::*; #(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [WIDTH-1:0]   i_x,
    input  logic [WIDTH-1:0]   i_y,
    output logic               o_done,
    output logic [2*WIDTH-1:0] o_p
);
    localparam int CW = $clog2(WIDTH + 1);
    logic [2*WIDTH-1:0] r_acc, r_mc;
    logic [WIDTH-1:0]   r_mp;
    logic [CW-1:0]      r_cnt;
    logic               r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_acc  <= '0;
                r_mc   <= {{WIDTH{1'b0}}, i_x};
                r_mp   <= i_y;
                r_cnt  <= CW'(WIDTH);
            end else if (r_busy) begin
                if (r_mp[0]) r_acc <= r_acc + r_mc;
                r_mc  <= r_mc << 1;
                r_mp  <= r_mp >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

FILE: rtl/core/rau_div.sv
// rau_div: restoring divider, one quotient bit per cycle; also gives remainder
// depends on rau_pkg
module rau_div import rau_pkg::*; #(
    parameter int W = 2 * DEF_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_n,
    input  logic [W-1:0] i_d,
    output logic         o_done,
    output logic [W-1:0] o_q,
    output logic [W-1:0] o_r
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  r_q, r_d;
    logic [W:0]    r_r;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [W:0]    trial;

    assign trial = {r_r[W-1:0], r_q[W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_n;
                r_d    <= i_d;
                r_r    <= '0;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                if (trial >= {1'b0, r_d}) begin
                    r_r <= trial - {1'b0, r_d};
                    r_q <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_r <= trial;
                    r_q <= {r_q[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_q    = r_q;
    assign o_r    = r_r[W-1:0];
endmodule

FILE: rtl/core/rational_arithmetic_unit.sv
// rational_arithmetic_unit: top level, sequencer around a shared multiplier and divider
// products on the shared multiplier, then a euclid loop and two final divides to reduce the result
// one transaction at a time; ready only while idle and the result slot is free
// run time is set by the euclid loop on the shared 2*WIDTH-bit restoring divider
// synchronous active-low reset clears sequencer and output valid
// depends on rau_pkg, rau_if, rau_mul, rau_div
module rational_arithmetic_unit import rau_pkg::*; #(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rau_if.sink   i_req,
    rau_if.source o_rsp
);
    localparam int W2 = 2 * WIDTH;

    typedef enum logic [3:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_COMB, S_GCD, S_Q1, S_Q2, S_CHK, S_OUT
    } t_state;

    t_state             r_state;
    logic [2:0]         r_op;
    logic               r_an, r_bn;
    logic [WIDTH-1:0]   r_anm, r_adm, r_bnm, r_bdm;
    logic [W2-1:0]      r_x, r_y, r_d, r_gx, r_gy, r_n;
    logic               r_neg;
    logic               r_vld;
    t_rsp               r_rsp;

    logic               mul_start, mul_done, div_start, div_done;
    logic [WIDTH-1:0]   mul_a, mul_b;
    logic [W2-1:0]      mul_p, div_n, div_d, div_q, div_r;

    rau_mul #(.WIDTH(WIDTH)) u_mul (
        .i_clk, .i_rst_n, .i_start(mul_start), .i_x(mul_a), .i_y(mul_b),
        .o_done(mul_done), .o_p(mul_p)
    );
    rau_div #(.W(W2)) u_div (
        .i_clk, .i_rst_n, .i_start(div_start), .i_n(div_n), .i_d(div_d),
        .o_done(div_done), .o_q(div_q), .o_r(div_r)
    );

    function automatic logic [WIDTH:0] magn(input logic [31:0] v);
        logic [WIDTH-1:0] m;
        m = v[WIDTH-1:0];
        return m[WIDTH-1] ? {1'b1, -m} : {1'b0, m};
    endfunction

    logic [WIDTH:0] ma_n, ma_d, mb_n, mb_d;
    assign ma_n = magn(i_req.data.a_num);
    assign ma_d = magn(i_req.data.a_den);
    assign mb_n = magn(i_req.data.b_num);
    assign mb_d = magn(i_req.data.b_den);

    assign i_req.ready = (r_state == S_IDLE) && !r_vld;
    assign o_rsp.valid = r_vld;
    assign o_rsp.data  = r_rsp;

    logic [W2-1:0] half;
    assign half = W2'(1) << (WIDTH - 1);

    always_comb begin
        mul_a = r_anm;
        mul_b = r_bdm;
        unique case (r_state)
            S_M1: begin mul_a = r_bnm; mul_b = r_adm; end
            S_M2: begin mul_a = r_adm; mul_b = r_bdm; end
            S_M3: begin mul_a = r_adm; mul_b = r_bnm; end
            default: begin
                if (r_op == OP_MUL) mul_b = r_bnm;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vld     <= 1'b0;
            mul_start <= 1'b0;
            div_start <= 1'b0;
        end else begin
            mul_start <= 1'b0;
            div_start <= 1'b0;
            if (o_rsp.valid && o_rsp.ready) r_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_op  <= i_req.data.opcode;
                        r_anm <= ma_n[WIDTH-1:0];
                        r_adm <= ma_d[WIDTH-1:0];
                        r_bnm <= mb_n[WIDTH-1:0];
                        r_bdm <= mb_d[WIDTH-1:0];
                        r_an  <= (ma_n[WIDTH-1:0] != '0) && (ma_n[WIDTH] != ma_d[WIDTH]);
                        r_bn  <= (mb_n[WIDTH-1:0] != '0) && (mb_n[WIDTH] != mb_d[WIDTH]);
                        r_rsp <= '0;
                        if (i_req.data.opcode == OP_NONE) begin
                            r_state <= S_OUT;
                        end else if (ma_d[WIDTH-1:0] == '0 ||
                                ((i_req.data.opcode <= OP_DIV || i_req.data.opcode == OP_CMP)
                                 && mb_d[WIDTH-1:0] == '0)) begin
                            r_rsp.status <= ST_ZDEN;
                            r_state      <= S_OUT;
                        end else if (i_req.data.opcode == OP_DIV && mb_n[WIDTH-1:0] == '0) begin
                            r_rsp.status <= ST_DIVZ;
                            r_state      <= S_OUT;
                        end else if (i_req.data.opcode == OP_NEG ||
                                     i_req.data.opcode == OP_SIMP) begin
                            r_x     <= {{WIDTH{1'b0}}, ma_n[WIDTH-1:0]};
                            r_d     <= {{WIDTH{1'b0}}, ma_d[WIDTH-1:0]};
                            r_state <= S_COMB;
                        end else begin
                            mul_start <= 1'b1;
                            r_state   <= S_M0;
                        end
                    end
                end
                S_M0: if (mul_done) begin
                    r_x <= mul_p;
                    mul_start <= 1'b1;
                    r_state <= S_M1;
                end
                S_M1: if (mul_done) begin
                    r_y <= mul_p;
                    if (r_op == OP_CMP) begin
                        r_state <= S_OUT;
                        if (r_an != r_bn) begin
                            r_rsp.less <= r_an;
                        end else begin
                            r_rsp.less  <= r_an ? (r_x > mul_p) : (r_x < mul_p);
                            r_rsp.equal <= r_x == mul_p;
                        end
                    end else begin
                        mul_start <= 1'b1;
                        r_state <= (r_op == OP_DIV) ? S_M3 : S_M2;
                    end
                end
                S_M2, S_M3: if (mul_done) begin
                    r_d <= mul_p;
                    r_state <= S_COMB;
                end
                S_COMB: begin
                    logic sy;
                    logic [W2-1:0] m;
                    logic s;
                    sy = (r_op == OP_SUB) ? (r_bnm != '0 && !r_bn) : r_bn;
                    m = r_x;
                    s = r_an != r_bn;
                    unique case (r_op)
                        OP_ADD, OP_SUB: begin
                            if (r_an == sy) begin m = r_x + r_y; s = r_an; end
                            else if (r_x >= r_y) begin m = r_x - r_y; s = r_an; end
                            else begin m = r_y - r_x; s = sy; end
                        end
                        OP_NEG: s = !r_an && r_anm != '0;
                        OP_SIMP: s = r_an;
                        default: m = r_x;
                    endcase
                    r_n   <= m;
                    r_neg <= s && m != '0;
                    if (m == '0) begin
                        r_rsp.res_den <= 31'd1;
                        r_state <= S_OUT;
                    end else begin
                        r_gx <= m;
                        r_gy <= r_d;
                        div_start <= 1'b1;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: if (div_done) begin
                    if (div_r == '0) begin
                        r_gx <= r_gy;
                        div_start <= 1'b1;
                        r_state <= S_Q1;
                    end else begin
                        r_gx <= r_gy;
                        r_gy <= div_r;
                        div_start <= 1'b1;
                    end
                end
                S_Q1: if (div_done) begin
                    r_n <= div_q;
                    div_start <= 1'b1;
                    r_state <= S_Q2;
                end
                S_Q2: if (div_done) begin
                    r_d <= div_q;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_d > half - 1 || r_n > (r_neg ? half : half - 1)) begin
                        r_rsp.status <= ST_OVF;
                    end else begin
                        r_rsp.res_num <= 32'($signed(r_neg ? -r_n[WIDTH-1:0] : r_n[WIDTH-1:0]));
                        r_rsp.res_den <= 31'(r_d);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_vld   <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        div_n = r_gx;
        div_d = r_gy;
        unique case (r_state)
            S_Q1: begin div_n = r_n; div_d = r_gx; end
            S_Q2: begin div_n = r_d; div_d = r_gx; end
            default: ;
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_rsp.valid) else $error("ready while result pending");
    a_one_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready) else $error("took two transactions");
    a_err_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.status != ST_OK) |->
        (o_rsp.data.res_den == '0 && o_rsp.data.res_num == '0))
        else $error("error result carries a value");
endmodule

FILE: test/rational_arithmetic_unit_tb.sv
// rational_arithmetic_unit_tb: self-checking testbench for the rational arithmetic unit
// predicts each response from the request fields and checks it in order
// depends on rau_pkg, rau_if and the rational_arithmetic_unit rtl
module rational_arithmetic_unit_tb;
    import rau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH = 32;
    localparam int NUM_RANDOM = 1130;

    logic i_clk;
    logic i_rst_n;
    logic req_fire;
    int   idle_pct;
    int   errors;
    int   checked;
    int   op_count [8];
    int   err_status_count;

    t_req stim_q [$];
    t_rsp pending_results [$];

    rau_if #(.t_payload(t_req)) req_if (i_clk);
    rau_if #(.t_payload(t_rsp)) rsp_if (i_clk);

    rational_arithmetic_unit #(.WIDTH(WIDTH)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] magnitude(input logic [31:0] v, output bit neg);
        logic [63:0] m;
        m = {32'd0, v};
        neg = v[31];
        if (v[31]) begin
            m = 64'h1_0000_0000 - m;
        end
        return m;
    endfunction

    function automatic t_rsp reduce_fraction(bit neg, logic [63:0] n, logic [63:0] d);
        t_rsp o;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] half;
        o = '0;
        half = 64'd1 << (WIDTH - 1);
        if (n == 0) begin
            o.res_den = 31'd1;
            return o;
        end
        x = n;
        y = d;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        n = n / x;
        d = d / x;
        if (d > half - 1 || n > (neg ? half : half - 1)) begin
            o.status = ST_OVF;
            return o;
        end
        o.res_num = neg ? (32'd0 - n[31:0]) : n[31:0];
        o.res_den = d[30:0];
        return o;
    endfunction

    function automatic t_rsp rational_result(t_req r);
        t_rsp o;
        t_op op;
        logic [63:0] an, ad, bn, bd, x, y, m;
        bit nn, nd, aneg, bneg, sx, sy, s, uses_b, lt, eq;
        o = '0;
        op = t_op'(r.opcode);
        an = magnitude(r.a_num, nn);
        ad = magnitude(r.a_den, nd);
        aneg = (an != 0) && (nn != nd);
        bn = magnitude(r.b_num, nn);
        bd = magnitude(r.b_den, nd);
        bneg = (bn != 0) && (nn != nd);
        uses_b = (op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP});
        if (op == OP_NONE) begin
            return o;
        end
        if (ad == 0 || (uses_b && bd == 0)) begin
            o.status = ST_ZDEN;
            return o;
        end
        x = an * bd;
        y = bn * ad;
        case (op)
            OP_ADD, OP_SUB: begin
                sx = aneg;
                sy = (op == OP_SUB) ? (bn != 0 && !bneg) : bneg;
                if (sx == sy) begin
                    m = x + y;
                    s = sx;
                end else if (x >= y) begin
                    m = x - y;
                    s = sx;
                end else begin
                    m = y - x;
                    s = sy;
                end
                o = reduce_fraction(s && m != 0, m, ad * bd);
            end
            OP_MUL: o = reduce_fraction(aneg != bneg, an * bn, ad * bd);
            OP_DIV: begin
                if (bn == 0) begin
                    o.status = ST_DIVZ;
                end else begin
                    o = reduce_fraction(aneg != bneg, an * bd, ad * bn);
                end
            end
            OP_NEG: o = reduce_fraction(!aneg && an != 0, an, ad);
            OP_CMP: begin
                if (aneg != bneg) begin
                    lt = aneg;
                    eq = 1'b0;
                end else if (aneg) begin
                    lt = x > y;
                    eq = x == y;
                end else begin
                    lt = x < y;
                    eq = x == y;
                end
                o.less = lt;
                o.equal = eq;
            end
            default: o = reduce_fraction(aneg, an, ad);
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
        errors++;
    endtask

    task automatic add_item(t_op op, int an, int ad, int bn, int bd);
        t_req r;
        r.opcode = op;
        r.a_num = an;
        r.a_den = ad;
        r.b_num = bn;
        r.b_den = bd;
        stim_q.push_back(r);
    endtask

    function automatic logic [31:0] rand_field(bit wide);
        int v;
        if (wide) begin
            return $urandom;
        end
        v = $urandom_range(400) - 200;
        return v;
    endfunction

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (stim_q.size() != 0 || req_if.valid || pending_results.size() != 0);
    endtask

    // driver: new transaction after acceptance or while idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            rsp_if.ready <= 1'b0;
        end else begin
            if (!req_if.valid || req_fire) begin
                if (stim_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    req_if.data <= stim_q.pop_front();
                    req_if.valid <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // monitor: check responses, then record accepted requests
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        req_fire <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (pending_results.size() == 0) begin
                $display("unexpected response at %0t", $realtime);
                errors++;
            end else begin
                want = pending_results.pop_front();
                checked++;
                if (got.res_num !== want.res_num)
                    report_mismatch("res_num", got.res_num, want.res_num);
                if (got.res_den !== want.res_den)
                    report_mismatch("res_den", {1'b0, got.res_den}, {1'b0, want.res_den});
                if (got.less !== want.less)
                    report_mismatch("less", 32'(got.less), 32'(want.less));
                if (got.equal !== want.equal)
                    report_mismatch("equal", 32'(got.equal), 32'(want.equal));
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
            end
        end
        if (i_rst_n && req_if.valid && req_if.ready) begin
            want = rational_result(req_if.data);
            pending_results.push_back(want);
            op_count[req_if.data.opcode]++;
            if (want.status != ST_OK)
                err_status_count++;
        end
    end

    initial begin
        t_req r;
        int   kind;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        req_fire = 1'b0;
        idle_pct = 20;
        errors = 0;
        checked = 0;
        err_status_count = 0;
        foreach (op_count[i]) op_count[i] = 0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_item(OP_ADD, 1, 2, 1, 3);
        add_item(OP_ADD, 1, 2, -1, 2);
        add_item(OP_SUB, 3, -4, -5, 6);
        add_item(OP_SUB, 32'h7fffffff, 1, 32'h80000000, 1);
        add_item(OP_ADD, 32'h80000000, 1, 32'h80000000, 1);
        add_item(OP_MUL, 32'h80000000, 32'h80000000, 7, -3);
        add_item(OP_MUL, 32'h7fffffff, 1, 32'h7fffffff, 1);
        add_item(OP_MUL, 0, -5, 9, 4);
        add_item(OP_DIV, 2, 3, 0, 5);
        add_item(OP_DIV, 2, 0, 0, 5);
        add_item(OP_DIV, -6, 35, 10, -21);
        add_item(OP_DIV, 1, 32'h7fffffff, 32'h7fffffff, 1);
        add_item(OP_NEG, 32'h80000000, 1, 0, 0);
        add_item(OP_NEG, 5, -10, 1, 1);
        add_item(OP_NEG, 0, 32'h80000000, 1, 1);
        add_item(OP_CMP, 1, -2, 1, 3);
        add_item(OP_CMP, -1, -2, 2, 4);
        add_item(OP_CMP, -3, 4, -1, 2);
        add_item(OP_CMP, 1, 0, 1, 1);
        add_item(OP_SIMP, 32'h80000000, 32'h80000000, 0, 0);
        add_item(OP_SIMP, 12, -18, 0, 0);
        add_item(OP_SIMP, 32'hffffffff, 32'hffffffff, 0, 0);
        add_item(OP_SIMP, 1, 32'h80000000, 0, 0);
        add_item(OP_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        add_item(OP_ADD, 5, 0, 1, 0);

        wait_drained();

        for (int i = 0; i < NUM_RANDOM; i++) begin
            kind = $urandom_range(99);
            r.opcode = 3'($urandom_range(7));
            r.a_num = rand_field(kind < 8);
            r.a_den = rand_field(kind < 8);
            r.b_num = rand_field(kind < 8);
            r.b_den = rand_field(kind < 8);
            if (kind >= 95) begin
                if ($urandom_range(1)) r.a_den = '0;
                else r.b_den = '0;
            end else if (kind >= 92) begin
                r.b_num = '0;
            end
            stim_q.push_back(r);
            if (i == NUM_RANDOM / 3) begin
                wait_drained();
                idle_pct = 0;
            end
            if (i == NUM_RANDOM / 2) begin
                wait_drained();
                idle_pct = 20;
            end
        end

        wait_drained();
        repeat (300) @(posedge i_clk);
        $display("checked %0d responses, %0d flagged with an error status", checked,
                 err_status_count);
        $display("per opcode: add %0d sub %0d mul %0d div %0d neg %0d cmp %0d simp %0d none %0d",
                 op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
                 op_count[5], op_count[6], op_count[7]);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #1s;
        $display("FAILURE");
        $finish;
    end
endmodule
